// ----- rtl/core/tldl_pkg.sv -----
// Package for the text line layout block: result struct, config codes,
// byte constants and width limits. No dependencies.
package tldl_pkg;

	localparam int MIN_LINE_WIDTH = 20;
	localparam int MAX_LINE_WIDTH = 126;
	localparam int MAX_TAB        = 256;

	localparam int COL_W   = 7;
	localparam int ABS_W   = 16;
	localparam int PHASE_W = 8;
	localparam int TAB_W   = 9;
	localparam int SKIP_W  = 12;
	localparam int CFG_W   = 12;
	localparam int X_W     = 18;

	localparam logic [ABS_W-1:0] ABS_MAX = '1;

	// config register indexes
	localparam logic [1:0] CFG_LINE_WIDTH = 2'd0;
	localparam logic [1:0] CFG_TAB_SIZE   = 2'd1;
	localparam logic [1:0] CFG_ENCODING   = 2'd2;
	localparam logic [1:0] CFG_H_SKIP     = 2'd3;

	localparam logic [1:0] ENC_ASCII = 2'd0;
	localparam logic [1:0] ENC_SJIS  = 2'd1;
	localparam logic [1:0] ENC_EUC   = 2'd2;

	localparam logic [7:0] BYTE_NUL   = 8'h00;
	localparam logic [7:0] BYTE_TAB   = 8'h09;
	localparam logic [7:0] BYTE_LF    = 8'h0a;
	localparam logic [7:0] BYTE_SPACE = 8'h20;
	localparam logic [7:0] SJIS_LO1   = 8'h81;
	localparam logic [7:0] SJIS_HI1   = 8'h9f;
	localparam logic [7:0] SJIS_LO2   = 8'he0;
	localparam logic [7:0] SJIS_HI2   = 8'hfc;
	localparam logic [7:0] EUC_LO     = 8'ha1;
	localparam logic [7:0] EUC_HI     = 8'hfe;

	typedef struct packed {
		logic [COL_W-1:0] start_col;
		logic [COL_W-1:0] cell_count;
		logic [7:0]       fill_byte;
		logic             line_done;
		logic [COL_W-1:0] line_length;
		logic             last;
	} res_t;

	// results of one byte: count is 0, 1 or 2
	typedef struct packed {
		logic [1:0] count;
		res_t       first;
		res_t       second;
	} issue_t;

endpackage

// ----- rtl/core/tldl_layout.sv -----
// Layout logic and line state: config registers, column/tab/lead state and
// the single-pass computation of the runs for one byte. Depends on tldl_pkg.
module tldl_layout (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wen,
	input  logic [1:0]                 cfg_index,
	input  logic [tldl_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                       step,
	input  logic [7:0]                 byte_in,
	output tldl_pkg::issue_t           issue
);
	import tldl_pkg::*;

	logic [COL_W-1:0]   line_width_q;
	logic [TAB_W-1:0]   tab_size_q;
	logic [1:0]         encoding_q;
	logic [SKIP_W-1:0]  h_skip_q;

	logic [ABS_W-1:0]   abs_q, abs_d;
	logic [PHASE_W-1:0] phase_q, phase_d;
	logic               pend_q, pend_d;
	logic [7:0]         lead_q, lead_d;

	logic [COL_W-1:0]   w7;
	logic [TAB_W-1:0]   t9;
	logic signed [X_W-1:0] x, ws, lo, hi, hi_raw, span;
	logic [TAB_W-1:0]   tab_n, run_n;
	logic [7:0]         run_fill;
	logic               vis, is_tab, is_end, is_lead;
	logic [ABS_W-1:0]   abs_p1, abs_p2, abs_tab;
	logic [ABS_W:0]     abs_sum;
	logic [PHASE_W-1:0] ph1, ph2;
	logic [COL_W-1:0]   len;
	res_t               run_res;

	function automatic logic [PHASE_W-1:0] next_phase(input logic [PHASE_W-1:0] p,
		input logic [TAB_W-1:0] t);
		logic [TAB_W-1:0] nx;
		nx = {1'b0, p} + TAB_W'(1);
		return (nx >= t) ? '0 : nx[PHASE_W-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= COL_W'(30);
			tab_size_q   <= TAB_W'(4);
			encoding_q   <= ENC_ASCII;
			h_skip_q     <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_LINE_WIDTH: line_width_q <= cfg_wdata[COL_W-1:0];
				CFG_TAB_SIZE:   tab_size_q   <= cfg_wdata[TAB_W-1:0];
				CFG_ENCODING:   encoding_q   <= cfg_wdata[1:0];
				CFG_H_SKIP:     h_skip_q     <= cfg_wdata[SKIP_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			abs_q   <= '0;
			phase_q <= '0;
			pend_q  <= 1'b0;
			lead_q  <= '0;
		end else if (step) begin
			abs_q   <= abs_d;
			phase_q <= phase_d;
			pend_q  <= pend_d;
			lead_q  <= lead_d;
		end
	end

	// effective register values
	always_comb begin
		if (line_width_q < COL_W'(MIN_LINE_WIDTH))
			w7 = COL_W'(MIN_LINE_WIDTH);
		else if (line_width_q > COL_W'(MAX_LINE_WIDTH))
			w7 = COL_W'(MAX_LINE_WIDTH);
		else
			w7 = line_width_q;
		if (tab_size_q == '0)
			t9 = TAB_W'(1);
		else if (tab_size_q > TAB_W'(MAX_TAB))
			t9 = TAB_W'(MAX_TAB);
		else
			t9 = tab_size_q;
	end

	assign ws = signed'({{(X_W-COL_W){1'b0}}, w7});
	assign x  = signed'({{(X_W-ABS_W){1'b0}}, abs_q})
		- signed'({{(X_W-SKIP_W){1'b0}}, h_skip_q});

	assign is_end = (byte_in == BYTE_LF) || (byte_in == BYTE_NUL);
	assign is_tab = (byte_in == BYTE_TAB);
	always_comb begin
		if (encoding_q == ENC_SJIS)
			is_lead = (byte_in >= SJIS_LO1 && byte_in <= SJIS_HI1)
				|| (byte_in >= SJIS_LO2 && byte_in <= SJIS_HI2);
		else if (encoding_q == ENC_EUC)
			is_lead = byte_in >= EUC_LO && byte_in <= EUC_HI;
		else
			is_lead = 1'b0;
	end

	// stale phase (tab_size shrank mid-line) gives a one-column tab
	assign tab_n    = ({1'b0, phase_q} < t9) ? t9 - {1'b0, phase_q} : TAB_W'(1);
	assign run_n    = is_tab ? tab_n : TAB_W'(1);
	assign run_fill = is_tab ? BYTE_SPACE : byte_in;

	// clip the run [x, x+n) to the visible cells [0, w)
	assign hi_raw = x + signed'({{(X_W-TAB_W){1'b0}}, run_n});
	assign lo     = (x < 0) ? '0 : x;
	assign hi     = (hi_raw > ws) ? ws : hi_raw;
	assign vis    = hi > lo;
	assign span   = hi - lo;

	always_comb begin
		run_res      = '0;
		run_res.last = 1'b1;
		if (vis) begin
			run_res.start_col  = lo[COL_W-1:0];
			run_res.cell_count = span[COL_W-1:0];
			run_res.fill_byte  = run_fill;
		end
	end

	always_comb begin
		if (x < 0)
			len = '0;
		else if (x > ws)
			len = w7;
		else
			len = x[COL_W-1:0];
	end

	assign abs_p1  = (abs_q == ABS_MAX) ? ABS_MAX : abs_q + ABS_W'(1);
	assign abs_p2  = (abs_q >= ABS_MAX - ABS_W'(1)) ? ABS_MAX : abs_q + ABS_W'(2);
	assign abs_sum = {1'b0, abs_q} + {{(ABS_W+1-TAB_W){1'b0}}, tab_n};
	assign abs_tab = abs_sum[ABS_W] ? ABS_MAX : abs_sum[ABS_W-1:0];
	assign ph1     = next_phase(phase_q, t9);
	assign ph2     = next_phase(ph1, t9);

	always_comb begin
		issue   = '0;
		abs_d   = abs_q;
		phase_d = phase_q;
		pend_d  = pend_q;
		lead_d  = lead_q;
		if (pend_q) begin
			// any byte is the trail here, the encoding is not consulted
			issue.count       = 2'd1;
			issue.first.last  = 1'b1;
			if (x == -1) begin
				issue.first.cell_count = COL_W'(1);
				issue.first.fill_byte  = BYTE_SPACE;
			end else if (x >= 0 && x < ws - 1) begin
				issue.count             = 2'd2;
				issue.first.start_col   = x[COL_W-1:0];
				issue.first.cell_count  = COL_W'(1);
				issue.first.fill_byte   = lead_q;
				issue.first.last        = 1'b0;
				issue.second.start_col  = x[COL_W-1:0] + COL_W'(1);
				issue.second.cell_count = COL_W'(1);
				issue.second.fill_byte  = byte_in;
				issue.second.last       = 1'b1;
			end else if (x == ws - 1) begin
				issue.first.start_col  = x[COL_W-1:0];
				issue.first.cell_count = COL_W'(1);
				issue.first.fill_byte  = BYTE_SPACE;
			end
			pend_d  = 1'b0;
			abs_d   = abs_p2;
			phase_d = ph2;
		end else if (is_end) begin
			issue.count             = 2'd1;
			issue.first.line_done   = 1'b1;
			issue.first.line_length = len;
			issue.first.last        = 1'b1;
			abs_d   = '0;
			phase_d = '0;
		end else if (is_tab) begin
			issue.count = 2'd1;
			issue.first = run_res;
			abs_d       = abs_tab;
			phase_d     = '0;
		end else if (is_lead) begin
			pend_d = 1'b1;
			lead_d = byte_in;
		end else begin
			issue.count = 2'd1;
			issue.first = run_res;
			abs_d       = abs_p1;
			phase_d     = ph1;
		end
	end

endmodule

// ----- rtl/core/tldl_out_queue.sv -----
// Two-slot result queue between the layout logic and the output channel.
// Takes all results of one byte at once. Depends on tldl_pkg.
module tldl_out_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tldl_pkg::issue_t issue,
	input  logic             pop,
	output logic             free,
	output logic             head_valid,
	output tldl_pkg::res_t   head
);
	import tldl_pkg::*;

	logic [1:0] count_q;
	res_t       slot0_q, slot1_q;

	// a byte is taken only when the queue is empty after this cycle's pop
	assign free       = (count_q == 2'd0) || (count_q == 2'd1 && pop);
	assign head_valid = count_q != 2'd0;
	assign head       = slot0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (push) begin
			count_q <= issue.count;
		end else if (pop) begin
			count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot0_q <= issue.first;
			slot1_q <= issue.second;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

endmodule

// ----- rtl/core/text_line_tab_dbcs_layout.sv -----
// Top level of the text line layout block: input register, layout logic and
// result queue. Depends on tldl_pkg, tldl_layout and tldl_out_queue.
//
//   channel   signals                                      width(s)
//   text      text_valid text_ready text_byte              1 1 8
//   out       out_valid out_ready start_col cell_count     1 1 7 7
//             fill_byte line_done line_length last         8 1 7 1
//   cfg       cfg_wen cfg_index cfg_wdata                  1 2 12
//
// One byte per clock while the output keeps up: each byte is registered in the
// input register and its runs are written into the result queue as it leaves.
// A byte that yields two runs (double-byte pair) holds the input register
// while the queue drains, as the output carries one run per beat.
// Reset clears the line state and loads the config defaults; no clearing pass.
// A stalled output holds one byte in the input register; text_ready then drops.
module text_line_tab_dbcs_layout (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       text_valid,
	output logic                       text_ready,
	input  logic [7:0]                 text_byte,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [tldl_pkg::COL_W-1:0] start_col,
	output logic [tldl_pkg::COL_W-1:0] cell_count,
	output logic [7:0]                 fill_byte,
	output logic                       line_done,
	output logic [tldl_pkg::COL_W-1:0] line_length,
	output logic                       last,
	input  logic                       cfg_wen,
	input  logic [1:0]                 cfg_index,
	input  logic [tldl_pkg::CFG_W-1:0] cfg_wdata
);
	import tldl_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       step, pop, free;
	issue_t     issue;
	res_t       head;

	assign pop        = out_valid && out_ready;
	assign step       = valid_s1 && free;
	assign text_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_ready) begin
			valid_s1 <= text_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_ready && text_valid) begin
			byte_s1 <= text_byte;
		end
	end

	tldl_layout u_layout (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.step      (step),
		.byte_in   (byte_s1),
		.issue     (issue)
	);

	tldl_out_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (step),
		.issue      (issue),
		.pop        (pop),
		.free       (free),
		.head_valid (out_valid),
		.head       (head)
	);

	assign start_col   = head.start_col;
	assign cell_count  = head.cell_count;
	assign fill_byte   = head.fill_byte;
	assign line_done   = head.line_done;
	assign line_length = head.line_length;
	assign last        = head.last;

`ifndef ASSERT_OFF
	// the trail run of a pair is queued with the lead run
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid)
		else $error("second run of a pair missing");

	a_done_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_done |-> cell_count == '0 && last)
		else $error("line end carries cells");

	a_len_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !line_done |-> line_length == '0)
		else $error("line length outside line end");

	a_run_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, start_col} + {1'b0, cell_count})
			<= (COL_W+1)'(MAX_LINE_WIDTH))
		else $error("run beyond the line");
`endif

endmodule
